// ----- hw/rtl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every rising edge outside reset
`define LPHT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("lpht assertion failed");

// check a property that must also hold while reset is asserted
`define LPHT_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("lpht assertion failed");

`endif

// ----- hw/rtl/lpht_pkg.sv -----
package lpht_pkg;

  localparam int unsigned SlotCount = 1024;
  localparam int unsigned KeyBytes  = 8;
  localparam int unsigned IdxW      = $clog2(SlotCount);
  localparam int unsigned CntW      = IdxW + 1;
  localparam int unsigned KeyW      = 64;
  localparam int unsigned LenW      = 4;
  localparam int unsigned ValW      = 64;
  localparam int unsigned LoadW     = CntW + 3;

  localparam logic [31:0] FnvBasis = 32'd2166136261;
  localparam logic [31:0] FnvPrime = 32'd16777619;
  localparam logic [LoadW-1:0] LoadLimit = LoadW'(3 * SlotCount);

  localparam logic [1:0] CMD_SET = 2'd0;
  localparam logic [1:0] CMD_GET = 2'd1;
  localparam logic [1:0] CMD_DEL = 2'd2;

  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_ABSENT = 2'd1;
  localparam logic [1:0] STATUS_FULL   = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_READ,
    ST_CHECK,
    ST_ACT
  } state_e;

  typedef struct packed {
    logic [KeyW-1:0] key;
    logic [LenW-1:0] len;
    logic [ValW-1:0] value;
  } slot_t;

  typedef struct packed {
    logic occ;
    logic tomb;
  } flag_t;

endpackage

// ----- hw/rtl/lpht_ram.sv -----
module lpht_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule

// ----- hw/rtl/linear_probe_hash_table.sv -----
// channel | handshake            | beat fields
// request | start, busy          | command_i, key_bytes_i, key_length_i, new_value_i
// result  | done_o (one cycle)   | status_o, was_new_key_o, read_value_o, live_count_o
// After reset the flag memory is cleared, one slot a cycle, while busy is high.
// After the accepting edge a request hashes its key one byte at a time in the
// FNV-1a multiplier, then probes slots (registered memory read, then compare)
// unless the command is invalid, the table is empty or a set would exceed the
// load limit, then updates; done_o is high the cycle after the update. busy
// drops with the result beat; the receiver cannot stall.
`include "assert_macros.svh"

module linear_probe_hash_table import lpht_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  command_i,
  input  logic [63:0] key_bytes_i,
  input  logic [3:0]  key_length_i,
  input  logic [63:0] new_value_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic        was_new_key_o,
  output logic [63:0] read_value_o,
  output logic [10:0] live_count_o
);

  state_e state_q, state_d;
  logic [IdxW-1:0] clr_q, clr_d;
  logic [1:0] cmd_q, cmd_d;
  logic [KeyW-1:0] key_q, key_d;
  logic [LenW-1:0] len_q, len_d;
  logic [ValW-1:0] val_q, val_d;
  logic [31:0] h_q, h_d;
  logic [LenW-1:0] hcnt_q, hcnt_d;
  logic [IdxW-1:0] idx_q, idx_d, steps_q, steps_d, tidx_q, tidx_d, slot_q, slot_d;
  logic seen_q, seen_d, ok_q, ok_d, hit_q, hit_d;
  logic [ValW-1:0] rdv_q, rdv_d;
  logic [CntW-1:0] live_q, live_d, tcnt_q, tcnt_d;
  logic done_q, done_d, fresh_q, fresh_d;
  logic [1:0] status_q, status_d;
  logic [ValW-1:0] rout_q, rout_d;

  logic [IdxW-1:0] addr;
  logic f_we, d_we;
  flag_t f_wdata, f_rdata;
  slot_t d_wdata, d_rdata;

  logic [KeyW-1:0] nkey;
  logic [LenW-1:0] nlen, eff_len;
  logic alive;
  logic [7:0] hbyte;
  logic [LoadW-1:0] used4;
  logic seen_n;
  logic [IdxW-1:0] tidx_n;

  lpht_ram #(.Width($bits(flag_t)), .Depth(SlotCount)) u_flags (
    .clk_i, .we_i(f_we), .addr_i(addr), .wdata_i(f_wdata), .rdata_o(f_rdata)
  );

  lpht_ram #(.Width($bits(slot_t)), .Depth(SlotCount)) u_slots (
    .clk_i, .we_i(d_we), .addr_i(addr), .wdata_i(d_wdata), .rdata_o(d_rdata)
  );

  always_comb begin
    eff_len = (key_length_i > LenW'(KeyBytes)) ? LenW'(KeyBytes) : key_length_i;
    nkey = '0;
    nlen = '0;
    alive = 1'b1;
    for (int i = 0; i < KeyBytes; i++) begin
      if (alive && (LenW'(i) < eff_len) && (key_bytes_i[8*i +: 8] != 8'd0)) begin
        nkey[8*i +: 8] = key_bytes_i[8*i +: 8];
        nlen = LenW'(i + 1);
      end else begin
        alive = 1'b0;
      end
    end
  end

  assign hbyte = key_q[{hcnt_q[2:0], 3'b000} +: 8];
  assign used4 = {(LoadW-2)'(live_q) + (LoadW-2)'(tcnt_q) + (LoadW-2)'(1), 2'b00};

  always_comb begin
    state_d = state_q;
    clr_d = clr_q;
    cmd_d = cmd_q;
    key_d = key_q;
    len_d = len_q;
    val_d = val_q;
    h_d = h_q;
    hcnt_d = hcnt_q;
    idx_d = idx_q;
    steps_d = steps_q;
    tidx_d = tidx_q;
    slot_d = slot_q;
    seen_d = seen_q;
    ok_d = ok_q;
    hit_d = hit_q;
    rdv_d = rdv_q;
    live_d = live_q;
    tcnt_d = tcnt_q;
    done_d = 1'b0;
    status_d = status_q;
    fresh_d = fresh_q;
    rout_d = rout_q;
    addr = idx_q;
    f_we = 1'b0;
    d_we = 1'b0;
    f_wdata = '0;
    d_wdata = '{key: key_q, len: len_q, value: val_q};
    seen_n = seen_q;
    tidx_n = tidx_q;
    unique case (state_q)
      ST_CLEAR: begin
        addr = clr_q;
        f_we = 1'b1;
        clr_d = clr_q + IdxW'(1);
        if (clr_q == '1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          cmd_d = command_i;
          key_d = nkey;
          len_d = nlen;
          val_d = new_value_i;
          h_d = FnvBasis;
          hcnt_d = '0;
          ok_d = 1'b0;
          hit_d = 1'b0;
          seen_d = 1'b0;
          steps_d = '0;
          state_d = (command_i == CMD_SET || command_i == CMD_GET ||
                     command_i == CMD_DEL) ? ST_HASH : ST_ACT;
        end
      end
      ST_HASH: begin
        if (hcnt_q == len_q) begin
          idx_d = h_q[IdxW-1:0];
          if ((cmd_q == CMD_SET && (used4 > LoadLimit))
              || (cmd_q != CMD_SET && live_q == '0)) begin
            state_d = ST_ACT;
          end else begin
            state_d = ST_READ;
          end
        end else begin
          h_d = (h_q ^ {24'd0, hbyte}) * FnvPrime;
          hcnt_d = hcnt_q + LenW'(1);
        end
      end
      ST_READ: begin
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (!f_rdata.occ) begin
          ok_d = 1'b1;
          slot_d = seen_q ? tidx_q : idx_q;
          state_d = ST_ACT;
        end else if (!f_rdata.tomb && d_rdata.len == len_q && d_rdata.key == key_q) begin
          ok_d = 1'b1;
          hit_d = 1'b1;
          slot_d = idx_q;
          rdv_d = d_rdata.value;
          state_d = ST_ACT;
        end else begin
          if (f_rdata.tomb && !seen_q) begin
            seen_n = 1'b1;
            tidx_n = idx_q;
          end
          seen_d = seen_n;
          tidx_d = tidx_n;
          if (steps_q == IdxW'(SlotCount - 1)) begin
            ok_d = seen_n;
            slot_d = tidx_n;
            state_d = ST_ACT;
          end else begin
            idx_d = idx_q + IdxW'(1);
            steps_d = steps_q + IdxW'(1);
            state_d = ST_READ;
          end
        end
      end
      ST_ACT: begin
        addr = slot_q;
        done_d = 1'b1;
        fresh_d = 1'b0;
        rout_d = '0;
        status_d = STATUS_ABSENT;
        state_d = ST_IDLE;
        if (cmd_q == CMD_SET) begin
          if (ok_q) begin
            status_d = STATUS_OK;
            d_we = 1'b1;
            f_we = 1'b1;
            f_wdata = '{occ: 1'b1, tomb: 1'b0};
            if (!hit_q) begin
              fresh_d = 1'b1;
              live_d = live_q + CntW'(1);
              if (seen_q && tcnt_q != '0) begin
                tcnt_d = tcnt_q - CntW'(1);
              end
            end
          end else begin
            status_d = STATUS_FULL;
          end
        end else if (cmd_q == CMD_GET) begin
          if (hit_q) begin
            status_d = STATUS_OK;
            rout_d = rdv_q;
          end
        end else if (cmd_q == CMD_DEL) begin
          if (hit_q) begin
            status_d = STATUS_OK;
            f_we = 1'b1;
            f_wdata = '{occ: 1'b1, tomb: 1'b1};
            tcnt_d = tcnt_q + CntW'(1);
            live_d = live_q - CntW'(1);
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q <= '0;
      live_q <= '0;
      tcnt_q <= '0;
      done_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q <= clr_d;
      live_q <= live_d;
      tcnt_q <= tcnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    key_q <= key_d;
    len_q <= len_d;
    val_q <= val_d;
    h_q <= h_d;
    hcnt_q <= hcnt_d;
    idx_q <= idx_d;
    steps_q <= steps_d;
    tidx_q <= tidx_d;
    slot_q <= slot_d;
    seen_q <= seen_d;
    ok_q <= ok_d;
    hit_q <= hit_d;
    rdv_q <= rdv_d;
    status_q <= status_d;
    fresh_q <= fresh_d;
    rout_q <= rout_d;
  end

  assign busy = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign status_o = status_q;
  assign was_new_key_o = fresh_q;
  assign read_value_o = rout_q;
  assign live_count_o = live_q;

  `LPHT_ASSERT(a_done_idle, done_o |-> !busy)
  `LPHT_ASSERT(a_start_busy, (start && !busy) |=> busy)
  `LPHT_ASSERT(a_load_bound, (4 * (live_q + tcnt_q)) <= (3 * SlotCount))
  `LPHT_ASSERT_ALWAYS(a_rst_clear, $rose(rst_ni) |-> (!done_o && live_q == '0))
endmodule

// ----- test/tb.sv -----
module tb;
  import lpht_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CMD_BAD = 2'd3;
  localparam int unsigned IdleLimit = 20000;
  localparam int unsigned PoolSize = 64;

  typedef struct packed {
    logic [1:0]  status;
    logic        fresh;
    logic [63:0] rd;
    logic [10:0] live;
  } reply_t;

  typedef struct {
    logic [1:0]  cmd;
    logic [63:0] key;
    logic [3:0]  len;
    logic [63:0] val;
    bit          typed;
    reply_t      want;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  command_i = '0;
  logic [63:0] key_bytes_i = '0;
  logic [3:0]  key_length_i = '0;
  logic [63:0] new_value_i = '0;
  logic        done_o;
  logic [1:0]  status_o;
  logic        was_new_key_o;
  logic [63:0] read_value_o;
  logic [10:0] live_count_o;

  linear_probe_hash_table dut (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  logic [63:0] tbl_key [SlotCount];
  logic [3:0]  tbl_len [SlotCount];
  logic [63:0] tbl_val [SlotCount];
  bit          tbl_occ [SlotCount];
  bit          tbl_tomb [SlotCount];
  int unsigned live_keys, tomb_keys;

  reply_t      pending_replies[$];
  int unsigned errors = 0;
  int unsigned idle_cycles = 0;
  int unsigned send_idle_pct = 0;
  logic [63:0] pool_key [PoolSize];
  logic [3:0]  pool_len [PoolSize];

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic logic [31:0] fnv1a(input logic [63:0] key, input int unsigned len);
    logic [31:0] h;
    h = FnvBasis;
    for (int i = 0; i < len; i++) begin
      h = (h ^ {24'd0, key[8*i +: 8]}) * FnvPrime;
    end
    return h;
  endfunction

  function automatic bit find_slot(input logic [63:0] key, input int unsigned len,
                                   output int unsigned slot);
    int unsigned idx;
    bit have_tomb;
    int unsigned tomb;
    idx = fnv1a(key, len) % SlotCount;
    have_tomb = 0;
    tomb = 0;
    for (int s = 0; s < SlotCount; s++) begin
      if (!tbl_occ[idx]) begin
        slot = have_tomb ? tomb : idx;
        return 1;
      end
      if (tbl_tomb[idx]) begin
        if (!have_tomb) begin
          have_tomb = 1;
          tomb = idx;
        end
      end else if (tbl_len[idx] == len && tbl_key[idx] == key) begin
        slot = idx;
        return 1;
      end
      idx = (idx + 1) % SlotCount;
    end
    slot = tomb;
    return have_tomb;
  endfunction

  function automatic reply_t apply_request(input logic [1:0] cmd, input logic [63:0] raw,
                                           input logic [3:0] len_in, input logic [63:0] val);
    reply_t r;
    logic [63:0] key;
    int unsigned len, lim, slot;
    bit is_new;
    lim = (len_in > KeyBytes) ? KeyBytes : len_in;
    key = '0;
    len = 0;
    while (len < lim && raw[8*len +: 8] != 8'd0) begin
      key[8*len +: 8] = raw[8*len +: 8];
      len++;
    end
    r = '0;
    r.status = STATUS_ABSENT;
    if (cmd == CMD_SET) begin
      if (4 * (live_keys + tomb_keys + 1) > 3 * SlotCount || !find_slot(key, len, slot)) begin
        r.status = STATUS_FULL;
      end else begin
        is_new = !tbl_occ[slot] || tbl_tomb[slot];
        if (is_new) begin
          if (tbl_tomb[slot] && tomb_keys > 0) tomb_keys--;
          live_keys++;
          tbl_key[slot] = key;
          tbl_len[slot] = len;
        end
        tbl_val[slot] = val;
        tbl_occ[slot] = 1;
        tbl_tomb[slot] = 0;
        r.status = STATUS_OK;
        r.fresh = is_new;
      end
    end else if (cmd == CMD_GET || cmd == CMD_DEL) begin
      if (live_keys != 0 && find_slot(key, len, slot) && tbl_occ[slot] && !tbl_tomb[slot]) begin
        r.status = STATUS_OK;
        if (cmd == CMD_GET) begin
          r.rd = tbl_val[slot];
        end else begin
          tbl_tomb[slot] = 1;
          tomb_keys++;
          live_keys--;
        end
      end
    end
    r.live = live_keys[10:0];
    return r;
  endfunction

  task automatic send_request(input row_t row);
    reply_t r;
    start <= 1'b1;
    command_i <= row.cmd;
    key_bytes_i <= row.key;
    key_length_i <= row.len;
    new_value_i <= row.val;
    do @(posedge clk_i); while (busy);
    r = apply_request(row.cmd, row.key, row.len, row.val);
    pending_replies.push_back(row.typed ? row.want : r);
    if ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      command_i <= 2'($urandom);
      key_bytes_i <= {$urandom, $urandom};
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  function automatic logic [63:0] random_key_bytes();
    logic [63:0] k;
    for (int i = 0; i < 8; i++) begin
      k[8*i +: 8] = ($urandom_range(15) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
    end
    return k;
  endfunction

  function automatic row_t random_row(input int unsigned set_pct, input bit fresh_keys);
    row_t row;
    int unsigned p, pick;
    row.typed = 0;
    row.want = '0;
    p = $urandom_range(99);
    if (p < set_pct) row.cmd = CMD_SET;
    else if (p < set_pct + (100 - set_pct) / 2) row.cmd = CMD_GET;
    else if (p < 98) row.cmd = CMD_DEL;
    else row.cmd = CMD_BAD;
    if (fresh_keys && row.cmd == CMD_SET) begin
      row.key = random_key_bytes();
      row.len = 4'($urandom_range(4, 15));
    end else begin
      pick = $urandom_range(PoolSize - 1);
      row.key = pool_key[pick];
      row.len = pool_len[pick];
      if ($urandom_range(7) == 0) row.key[63:56] = 8'($urandom);
    end
    row.val = {$urandom, $urandom};
    return row;
  endfunction

  always @(posedge clk_i) begin
    reply_t w;
    if (rst_ni && done_o) begin
      if (pending_replies.size() == 0) begin
        report("unexpected beat", 64'(status_o), 64'd0);
      end else begin
        w = pending_replies.pop_front();
        if (status_o !== w.status) report("status", 64'(status_o), 64'(w.status));
        if (was_new_key_o !== w.fresh) report("was_new_key", 64'(was_new_key_o), 64'(w.fresh));
        if (read_value_o !== w.rd) report("read_value", read_value_o, w.rd);
        if (live_count_o !== w.live) report("live_count", 64'(live_count_o), 64'(w.live));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || done_o || (start && !busy)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("FAIL linear_probe_hash_table");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    row_t directed[$];
    live_keys = 0;
    tomb_keys = 0;
    foreach (tbl_occ[i]) begin
      tbl_occ[i] = 0;
      tbl_tomb[i] = 0;
    end
    foreach (pool_key[i]) begin
      pool_key[i] = random_key_bytes();
      pool_len[i] = 4'($urandom_range(0, 15));
    end
    directed = '{
      '{CMD_GET, 64'h0, 4'd0, 64'h0, 1, '{STATUS_ABSENT, 1'b0, 64'h0, 11'd0}},
      '{CMD_DEL, 64'h41, 4'd1, 64'h0, 1, '{STATUS_ABSENT, 1'b0, 64'h0, 11'd0}},
      '{CMD_SET, 64'h0, 4'd0, '1, 1, '{STATUS_OK, 1'b1, 64'h0, 11'd1}},
      '{CMD_GET, 64'hFFFF, 4'd0, 64'h0, 1, '{STATUS_OK, 1'b0, '1, 11'd1}},
      '{CMD_SET, '1, 4'd15, 64'h0, 1, '{STATUS_OK, 1'b1, 64'h0, 11'd2}},
      '{CMD_GET, '1, 4'd8, '1, 1, '{STATUS_OK, 1'b0, 64'h0, 11'd2}},
      '{CMD_SET, '1, 4'd8, 64'h1234_5678_9ABC_DEF0, 1, '{STATUS_OK, 1'b0, 64'h0, 11'd2}},
      '{CMD_SET, 64'hFF00_0041, 4'd4, 64'h5, 1, '{STATUS_OK, 1'b1, 64'h0, 11'd3}},
      '{CMD_GET, 64'h41, 4'd1, 64'h0, 1, '{STATUS_OK, 1'b0, 64'h5, 11'd3}},
      '{CMD_BAD, 64'h41, 4'd1, 64'h0, 1, '{STATUS_ABSENT, 1'b0, 64'h0, 11'd3}},
      '{CMD_GET, 64'h4141, 4'd2, 64'h0, 1, '{STATUS_ABSENT, 1'b0, 64'h0, 11'd3}},
      '{CMD_DEL, 64'h0, 4'd0, 64'h0, 1, '{STATUS_OK, 1'b0, 64'h0, 11'd2}},
      '{CMD_GET, 64'h0, 4'd0, 64'h0, 1, '{STATUS_ABSENT, 1'b0, 64'h0, 11'd2}},
      '{CMD_SET, 64'h0, 4'd9, 64'h7, 0, '0},
      '{CMD_GET, 64'h0, 4'd0, 64'h0, 0, '0},
      '{CMD_DEL, 64'hFF00_0041, 4'd15, 64'h0, 0, '0},
      '{CMD_GET, 64'h41, 4'd1, 64'h0, 0, '0},
      '{CMD_SET, 64'h8000_0000_0000_0001, 4'd8, 64'h8000_0000_0000_0000, 0, '0},
      '{CMD_GET, 64'h8000_0000_0000_0001, 4'd8, 64'h0, 0, '0},
      '{CMD_DEL, '1, 4'd8, 64'h0, 0, '0}
    };
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed[i]) send_request(directed[i]);

    send_idle_pct = 29;
    for (int i = 0; i < 300; i++) send_request(random_row(45, 0));
    start <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);

    send_idle_pct = 69;
    for (int i = 0; i < 250; i++) send_request(random_row(45, 0));

    send_idle_pct = 0;
    for (int i = 0; i < 730; i++) send_request(random_row(85, i % 3 != 0));
    start <= 1'b0;

    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (errors == 0) begin
      $display("PASS linear_probe_hash_table");
    end else begin
      $display("FAIL linear_probe_hash_table");
    end
    $finish;
  end

endmodule
